### sv/lut3d_pkg.sv
// ----------------------------------------------------------------------------
// lut3d_pkg
// Shared types and constants of the 3D LUT tetrahedral interpolator.
// ----------------------------------------------------------------------------
package lut3d_pkg;

  localparam int GridMax    = 33;
  localparam int TableDepth = GridMax * GridMax * GridMax;
  localparam int AddrW      = 16;
  localparam int SizeW      = 6;
  localparam int SqW        = 11;
  localparam int FracW      = 16;
  localparam int WeightW    = FracW + 1;
  localparam int EntryW     = 16;
  localparam int ProdW      = WeightW + 1 + EntryW;
  localparam int AccW       = ProdW + 2;
  localparam int ShiftOut   = EntryW - 2 + FracW;
  localparam int ScaleW     = 16;
  localparam int OpW        = 9;

  localparam logic [1:0] CfgIdxScale   = 2'd0;
  localparam logic [1:0] CfgIdxSize    = 2'd1;
  localparam logic [1:0] CfgIdxOpacity = 2'd2;

  typedef logic [2:0][EntryW-1:0] entry_t;

  typedef struct packed {
    logic [3:0][WeightW-1:0] w;
    logic [2:0][7:0]         px;
  } side_t;

  typedef struct packed {
    logic [ScaleW-1:0] scale;
    logic [SizeW-1:0]  size;
    logic [OpW-1:0]    opacity;
  } cfg_t;

endpackage

### sv/lut3d_tetrahedral_interp_top.sv
// ----------------------------------------------------------------------------
// lut3d_tetrahedral_interp_top
// 3D color LUT with tetrahedral interpolation and opacity blend.
//
// Input channel (in_valid_i/in_ready_o): mode 0 words carry a pixel, mode 1
// words store one table entry at entry_address; table writes give no output.
// Output channel (out_valid_o/out_ready_i): one blended pixel per pixel word,
// in input order. Config channel (cfg_valid_i/cfg_ready_o) writes lut_scale,
// lut_size and opacity; it is always ready. The user is to use it only while
// the block is idle; the block itself does not enforce this. Eight register
// stages: multiply, split/tetrahedron, address, table read, weight products,
// vertex sum, rounding, blend. One word per cycle is taken while the output
// is not stalled; the four table reads per pixel are served by two dual-read
// copies. Each stage holds its word while the next is full and stalled, so a
// stalled receiver fills the pipe and only then drops in_ready_o. Reset clears
// the valid bits and loads default registers; table contents are undefined
// until written.
// ----------------------------------------------------------------------------
module lut3d_tetrahedral_interp_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  pixel_red_i,
  input  logic [7:0]  pixel_green_i,
  input  logic [7:0]  pixel_blue_i,
  input  logic [15:0] entry_address_i,
  input  logic [15:0] entry_red_i,
  input  logic [15:0] entry_green_i,
  input  logic [15:0] entry_blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o
);

  logic [15:0]     scale_q;
  logic [5:0]      size_q;
  logic [8:0]      opacity_q;
  lut3d_pkg::cfg_t cfg;

  logic [8:1] v_q;
  logic [4:1] mode_q;
  logic [9:1] adv;
  logic [8:1] v_in;

  logic [3:0][lut3d_pkg::AddrW-1:0] raddr;
  lut3d_pkg::side_t        side3, side4;
  logic [lut3d_pkg::AddrW-1:0] waddr3;
  lut3d_pkg::entry_t       wdata3;
  lut3d_pkg::entry_t [3:0] rdata;
  logic [2:0][7:0]         rgb;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= 16'd8224;
      size_q    <= 6'd33;
      opacity_q <= 9'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lut3d_pkg::CfgIdxScale:   scale_q   <= cfg_data_i;
        lut3d_pkg::CfgIdxSize:    size_q    <= cfg_data_i[5:0];
        lut3d_pkg::CfgIdxOpacity: opacity_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.scale = scale_q;
    if (size_q == 6'd0) begin
      cfg.size = 6'd1;
    end else if (size_q > 6'(lut3d_pkg::GridMax)) begin
      cfg.size = 6'(lut3d_pkg::GridMax);
    end else begin
      cfg.size = size_q;
    end
    cfg.opacity = (opacity_q > 9'd256) ? 9'd256 : opacity_q;
  end

  always_comb begin
    adv[9] = out_ready_i;
    for (int k = 8; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    v_in[1] = in_valid_i;
    for (int k = 2; k <= 8; k++) begin
      v_in[k] = v_q[k-1];
    end
    v_in[5] = v_q[4] && !mode_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      mode_q <= '0;
    end else begin
      for (int k = 1; k <= 8; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_in[k];
        end
      end
      if (adv[1]) begin
        mode_q[1] <= mode_i;
      end
      for (int k = 2; k <= 4; k++) begin
        if (adv[k]) begin
          mode_q[k] <= mode_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = adv[1];
  assign out_valid_o = v_q[8];

  lut3d_addr u_addr (
    .clk_i   (clk_i),
    .en_i    (adv[3:1]),
    .cfg_i   (cfg),
    .px_i    ({pixel_blue_i, pixel_green_i, pixel_red_i}),
    .waddr_i (entry_address_i),
    .wdata_i ({entry_blue_i, entry_green_i, entry_red_i}),
    .raddr_o (raddr),
    .side_o  (side3),
    .waddr_o (waddr3),
    .wdata_o (wdata3)
  );

  lut3d_mem u_mem (
    .clk_i   (clk_i),
    .en_i    (adv[4]),
    .we_i    (v_q[3] && mode_q[3]),
    .waddr_i (waddr3),
    .wdata_i (wdata3),
    .raddr_i (raddr),
    .side_i  (side3),
    .rdata_o (rdata),
    .side_o  (side4)
  );

  lut3d_accum u_accum (
    .clk_i   (clk_i),
    .en_i    (adv[8:5]),
    .cfg_i   (cfg),
    .rdata_i (rdata),
    .side_i  (side4),
    .rgb_o   (rgb)
  );

  assign out_red_o   = rgb[0];
  assign out_green_o = rgb[1];
  assign out_blue_o  = rgb[2];

endmodule

### sv/lut3d_addr.sv
// ----------------------------------------------------------------------------
// lut3d_addr
// Grid split, tetrahedron select, vertex weights and table addresses.
// ----------------------------------------------------------------------------
module lut3d_addr (
  input  logic                                clk_i,
  input  logic [2:0]                          en_i,
  input  lut3d_pkg::cfg_t                     cfg_i,
  input  logic [2:0][7:0]                     px_i,
  input  logic [lut3d_pkg::AddrW-1:0]         waddr_i,
  input  lut3d_pkg::entry_t                   wdata_i,
  output logic [3:0][lut3d_pkg::AddrW-1:0]    raddr_o,
  output lut3d_pkg::side_t                    side_o,
  output logic [lut3d_pkg::AddrW-1:0]         waddr_o,
  output lut3d_pkg::entry_t                   wdata_o
);

  localparam int SW = lut3d_pkg::SizeW;
  localparam int FW = lut3d_pkg::FracW;
  localparam int WW = lut3d_pkg::WeightW;

  logic [2:0][23:0]    prod;
  logic [2:0][7:0]     idx1_q;
  logic [2:0][FW-1:0]  frac1_q;
  logic [2:0][7:0]     px1_q, px2_q;
  logic [lut3d_pkg::AddrW-1:0] waddr1_q, waddr2_q, waddr3_q;
  lut3d_pkg::entry_t   wdata1_q, wdata2_q, wdata3_q;

  logic [2:0][SW-1:0]  lo, hi;
  logic [2:0][FW-1:0]  f;
  logic [7:0]          lim;
  logic [3:0][WW-1:0]  w;
  logic [3:0][2:0]     vc;
  logic [3:0][2:0][SW-1:0] vi, vi2_q;
  logic [3:0][WW-1:0]  w2_q;
  logic [lut3d_pkg::SqW-1:0] ss2_q;
  logic [11:0]         ss_full;
  logic [3:0][lut3d_pkg::AddrW-1:0] addr, addr3_q;
  lut3d_pkg::side_t    side3_q;
  logic                rg, gb, br, bg;
  logic [WW-1:0]       one;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = 24'(px_i[c]) * 24'(cfg_i.scale);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int c = 0; c < 3; c++) begin
        idx1_q[c]  <= prod[c][23:16];
        frac1_q[c] <= prod[c][15:0];
      end
      px1_q    <= px_i;
      waddr1_q <= waddr_i;
      wdata1_q <= wdata_i;
    end
  end

  always_comb begin
    lim = 8'(cfg_i.size) - 8'd1;
    for (int c = 0; c < 3; c++) begin
      if (idx1_q[c] >= lim) begin
        lo[c] = cfg_i.size - SW'(1);
        hi[c] = cfg_i.size - SW'(1);
        f[c]  = '0;
      end else begin
        lo[c] = idx1_q[c][SW-1:0];
        hi[c] = idx1_q[c][SW-1:0] + SW'(1);
        f[c]  = frac1_q[c];
      end
    end
    one = WW'(1) << FW;
    rg  = f[0] > f[1];
    gb  = f[1] > f[2];
    br  = f[2] > f[0];
    bg  = f[2] > f[1];
    vc[0] = 3'd0;
    vc[3] = 3'd7;
    if (rg) begin
      if (gb) begin
        w[0] = one - WW'(f[0]); vc[1] = 3'd4; w[1] = WW'(f[0]) - WW'(f[1]);
        vc[2] = 3'd6; w[2] = WW'(f[1]) - WW'(f[2]); w[3] = WW'(f[2]);
      end else if (br) begin
        w[0] = one - WW'(f[2]); vc[1] = 3'd1; w[1] = WW'(f[2]) - WW'(f[0]);
        vc[2] = 3'd5; w[2] = WW'(f[0]) - WW'(f[1]); w[3] = WW'(f[1]);
      end else begin
        w[0] = one - WW'(f[0]); vc[1] = 3'd4; w[1] = WW'(f[0]) - WW'(f[2]);
        vc[2] = 3'd5; w[2] = WW'(f[2]) - WW'(f[1]); w[3] = WW'(f[1]);
      end
    end else begin
      if (bg) begin
        w[0] = one - WW'(f[2]); vc[1] = 3'd1; w[1] = WW'(f[2]) - WW'(f[1]);
        vc[2] = 3'd3; w[2] = WW'(f[1]) - WW'(f[0]); w[3] = WW'(f[0]);
      end else if (br) begin
        w[0] = one - WW'(f[1]); vc[1] = 3'd2; w[1] = WW'(f[1]) - WW'(f[2]);
        vc[2] = 3'd3; w[2] = WW'(f[2]) - WW'(f[0]); w[3] = WW'(f[0]);
      end else begin
        w[0] = one - WW'(f[1]); vc[1] = 3'd2; w[1] = WW'(f[1]) - WW'(f[0]);
        vc[2] = 3'd6; w[2] = WW'(f[0]) - WW'(f[2]); w[3] = WW'(f[2]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      vi[k][0] = vc[k][2] ? hi[0] : lo[0];
      vi[k][1] = vc[k][1] ? hi[1] : lo[1];
      vi[k][2] = vc[k][0] ? hi[2] : lo[2];
    end
    ss_full = 12'(cfg_i.size) * 12'(cfg_i.size);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      vi2_q    <= vi;
      w2_q     <= w;
      ss2_q    <= ss_full[lut3d_pkg::SqW-1:0];
      px2_q    <= px1_q;
      waddr2_q <= waddr1_q;
      wdata2_q <= wdata1_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      addr[k] = lut3d_pkg::AddrW'(17'(vi2_q[k][0]) * 17'(ss2_q))
              + lut3d_pkg::AddrW'(12'(vi2_q[k][1]) * 12'(cfg_i.size))
              + lut3d_pkg::AddrW'(vi2_q[k][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      addr3_q    <= addr;
      side3_q.w  <= w2_q;
      side3_q.px <= px2_q;
      waddr3_q   <= waddr2_q;
      wdata3_q   <= wdata2_q;
    end
  end

  assign raddr_o = addr3_q;
  assign side_o  = side3_q;
  assign waddr_o = waddr3_q;
  assign wdata_o = wdata3_q;

endmodule

### sv/lut3d_mem.sv
// ----------------------------------------------------------------------------
// lut3d_mem
// Table storage: two copies, two read ports each, four vertex reads a cycle while enabled.
// ----------------------------------------------------------------------------
module lut3d_mem (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic                             we_i,
  input  logic [lut3d_pkg::AddrW-1:0]      waddr_i,
  input  lut3d_pkg::entry_t                wdata_i,
  input  logic [3:0][lut3d_pkg::AddrW-1:0] raddr_i,
  input  lut3d_pkg::side_t                 side_i,
  output lut3d_pkg::entry_t [3:0]          rdata_o,
  output lut3d_pkg::side_t                 side_o
);

  lut3d_pkg::entry_t mem_a [lut3d_pkg::TableDepth];
  lut3d_pkg::entry_t mem_b [lut3d_pkg::TableDepth];
  lut3d_pkg::entry_t [3:0] rd_q;
  lut3d_pkg::side_t  side_q;
  logic              wr;

  assign wr = en_i && we_i &&
              (waddr_i < lut3d_pkg::AddrW'(lut3d_pkg::TableDepth));

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_a[waddr_i] <= wdata_i;
      mem_b[waddr_i] <= wdata_i;
    end
    if (en_i) begin
      rd_q[0] <= mem_a[raddr_i[0]];
      rd_q[1] <= mem_a[raddr_i[1]];
      rd_q[2] <= mem_b[raddr_i[2]];
      rd_q[3] <= mem_b[raddr_i[3]];
      side_q  <= side_i;
    end
  end

  assign rdata_o = rd_q;
  assign side_o  = side_q;

endmodule

### sv/lut3d_accum.sv
// ----------------------------------------------------------------------------
// lut3d_accum
// Weighted vertex sum, rounding to 8 bits and opacity blend.
// ----------------------------------------------------------------------------
module lut3d_accum (
  input  logic                    clk_i,
  input  logic [3:0]              en_i,
  input  lut3d_pkg::cfg_t         cfg_i,
  input  lut3d_pkg::entry_t [3:0] rdata_i,
  input  lut3d_pkg::side_t        side_i,
  output logic [2:0][7:0]         rgb_o
);

  localparam int PW = lut3d_pkg::ProdW;
  localparam int AW = lut3d_pkg::AccW;
  localparam int TW = AW + 8;

  logic signed [PW-1:0] prod [4][3];
  logic signed [PW-1:0] prod5_q [4][3];
  logic signed [AW-1:0] acc [3];
  logic signed [AW-1:0] acc6_q [3];
  logic [2:0][7:0]      px5_q, px6_q, px7_q;
  logic [2:0][7:0]      byte7, byte7_q, res, res8_q;
  logic [TW-1:0]        t [3];
  logic [TW-1:0]        m [3];
  logic signed [19:0]   bl [3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        prod[k][c] = PW'($signed({1'b0, side_i.w[k]}) * $signed(rdata_i[k][c]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod5_q <= prod;
      px5_q   <= side_i.px;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = AW'(prod5_q[0][c]) + AW'(prod5_q[1][c])
             + AW'(prod5_q[2][c]) + AW'(prod5_q[3][c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      acc6_q <= acc;
      px6_q  <= px5_q;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      t[c] = (TW'(acc6_q[c]) << 8) - TW'(acc6_q[c])
           + (TW'(1) << (lut3d_pkg::ShiftOut - 1));
      m[c] = t[c] >> lut3d_pkg::ShiftOut;
      if (acc6_q[c] <= 0) begin
        byte7[c] = 8'd0;
      end else if (m[c] > TW'(255)) begin
        byte7[c] = 8'd255;
      end else begin
        byte7[c] = m[c][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      byte7_q <= byte7;
      px7_q   <= px6_q;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bl[c] = ($signed(20'(px7_q[c])) <<< 8)
            + ($signed(20'(byte7_q[c])) - $signed(20'(px7_q[c])))
            * $signed(20'(cfg_i.opacity));
      res[c] = bl[c][15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      res8_q <= res;
    end
  end

  assign rgb_o = res8_q;

endmodule
